// File: rtl/ltms_pkg.sv
// shared types and constants for the loser tree merge selector
// no dependencies; imported by every rtl module of the block
package ltms_pkg;

   localparam int FUNC_W          = 2;
   localparam int IDX_W           = 7;
   localparam int VAL_W           = 32;
   localparam int COUNT_W         = 7;
   localparam int MAX_PLAYERS_DEF = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_BUILD  = 2'd1,
      FUNC_REPLAY = 2'd2
   } ltms_func_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  player_index;
      logic [VAL_W-1:0]  value;
   } ltms_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] winner_index;
      logic [VAL_W-1:0] winner_value;
   } ltms_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ltms_stat_type;

endpackage

// File: rtl/ltms_match.sv
// shared match unit: one key compare, picks winner and loser of a game
// depends on ltms_pkg for parameter defaults
module ltms_match import ltms_pkg::*; #(
   parameter int MAX_PLAYERS = MAX_PLAYERS_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic [$clog2(MAX_PLAYERS+1)-1:0] a_idx,
   input  logic [VALUE_WIDTH-1:0]           a_key,
   input  logic [$clog2(MAX_PLAYERS+1)-1:0] b_idx,
   input  logic [VALUE_WIDTH-1:0]           b_key,
   output logic [$clog2(MAX_PLAYERS+1)-1:0] win_idx,
   output logic [$clog2(MAX_PLAYERS+1)-1:0] lose_idx,
   output logic [VALUE_WIDTH-1:0]           win_key
);

   logic a_wins;

   // on equal keys side b keeps the win
   assign a_wins   = a_key < b_key;
   assign win_idx  = a_wins ? a_idx : b_idx;
   assign lose_idx = a_wins ? b_idx : a_idx;
   assign win_key  = a_wins ? a_key : b_key;

endmodule

// File: rtl/ltms_seq.sv
// sequencer, tree memories and datapath of the loser tree
// depends on ltms_pkg and ltms_match
module ltms_seq import ltms_pkg::*; #(
   parameter int MAX_PLAYERS = MAX_PLAYERS_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_go,
   input  ltms_req_type        req,
   input  logic [COUNT_W-1:0]  player_count,
   output ltms_stat_type       stat,
   output ltms_rsp_type        rsp_next
);

   localparam int IW = $clog2(MAX_PLAYERS + 1);
   localparam int NW = $clog2(MAX_PLAYERS);
   localparam int PW = $clog2(2 * MAX_PLAYERS);
   localparam int EW = ((IW > IDX_W) ? IW : IDX_W) + 1;
   localparam int KW = VALUE_WIDTH;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SETUP  = 8'b0000_0010,
      ST_B_WIN  = 8'b0000_0100,
      ST_B_KEY  = 8'b0000_1000,
      ST_B_CMP  = 8'b0001_0000,
      ST_R_LOSE = 8'b0010_0000,
      ST_R_KEY  = 8'b0100_0000,
      ST_R_CMP  = 8'b1000_0000
   } ltms_state_type;

   ltms_state_type state_ff, state_in;

   logic [IW-1:0] count_ff, count_in;
   logic [PW-1:0] low_ext_ff, low_ext_in;
   logic [PW-1:0] offset_ff, offset_in;
   logic [NW-1:0] node_ff, node_in;
   logic [IW-1:0] chal_ff, chal_in;
   logic [KW-1:0] chal_key_ff, chal_key_in;
   logic [IW-1:0] l_idx_ff, l_idx_in;
   logic [IW-1:0] r_idx_ff, r_idx_in;

   // tree memories
   logic [KW-1:0] pv_mem [MAX_PLAYERS];
   logic [IW-1:0] ln_mem [MAX_PLAYERS];
   logic [IW-1:0] ws_mem [MAX_PLAYERS];

   logic          pv_we, pv_re;
   logic [NW-1:0] pv_waddr, pv_raddr_a, pv_raddr_b;
   logic [KW-1:0] pv_wdata, pv_rd_a_ff, pv_rd_b_ff;
   logic          ln_we, ln_re;
   logic [IW-1:0] ln_rd_ff;
   logic          ws_we, ws_re;
   logic [NW-1:0] ws_raddr_a, ws_raddr_b;
   logic [IW-1:0] ws_rd_a_ff, ws_rd_b_ff;

   // request decode
   logic [EW-1:0]       idx_e, cnt_e, max_e, built_e, n_sel_e;
   logic [IW-1:0]       idx_iw, idx_m1, n_sat, nm1, s_pow, s_diff;
   logic                load_ok, rep_ok;
   logic [PW-1:0]       idx_pw, pos, count_pw;
   logic [KW+VAL_W-1:0] val_wide;
   logic [KW-1:0]       val_key;

   // build children
   logic [PW-1:0] cl, cr, leaf_l, leaf_r;
   logic          int_l, int_r;
   logic [IW-1:0] l_sel, r_sel, l_m1, r_m1;

   // match unit
   logic [IW-1:0]          b_idx, win_idx, lose_idx;
   logic [KW-1:0]          b_key, win_key;
   logic                   last_node;
   logic [IW+IDX_W-1:0]    win_idx_wide;
   logic [KW+VAL_W-1:0]    win_key_wide;

   assign idx_e   = EW'(req.player_index);
   assign cnt_e   = EW'(player_count);
   assign max_e   = EW'(MAX_PLAYERS);
   assign built_e = EW'(count_ff);
   assign idx_iw  = idx_e[IW-1:0];
   assign idx_m1  = idx_iw - IW'(1);
   assign load_ok = (idx_e != '0) && (idx_e <= max_e);
   assign rep_ok  = (idx_e != '0) && (idx_e <= built_e);

   assign val_wide = {{KW{1'b0}}, req.value};
   assign val_key  = val_wide[KW-1:0];

   // count saturated to the legal range, then the lowExt/offset layout
   always_comb begin
      if (cnt_e < EW'(2)) begin
         n_sel_e = EW'(2);
      end else if (cnt_e > max_e) begin
         n_sel_e = max_e;
      end else begin
         n_sel_e = cnt_e;
      end
   end

   assign n_sat = n_sel_e[IW-1:0];
   assign nm1   = n_sat - IW'(1);

   // largest power of two not above count - 1
   always_comb begin
      s_pow = '0;
      for (int b = 0; b < IW; b++) begin
         if (nm1[b]) begin
            s_pow = IW'(1) << b;
         end
      end
   end

   assign s_diff = n_sat - s_pow;

   // leaf position of the replayed player
   assign idx_pw   = PW'(idx_iw);
   assign count_pw = PW'(count_ff);
   assign pos = (idx_pw <= low_ext_ff) ? offset_ff + idx_pw
                                       : idx_pw + count_pw - PW'(1) - low_ext_ff;

   // children of the node under play
   assign cl     = {node_ff, 1'b0};
   assign cr     = {node_ff, 1'b1};
   assign int_l  = cl < count_pw;
   assign int_r  = cr < count_pw;
   assign leaf_l = (cl > offset_ff) ? cl - offset_ff : cl + low_ext_ff + PW'(1) - count_pw;
   assign leaf_r = (cr > offset_ff) ? cr - offset_ff : cr + low_ext_ff + PW'(1) - count_pw;

   always_comb begin
      if (state_ff == ST_R_KEY) begin
         l_sel = ln_rd_ff;
      end else if (int_l) begin
         l_sel = ws_rd_a_ff;
      end else begin
         l_sel = leaf_l[IW-1:0];
      end
      r_sel = int_r ? ws_rd_b_ff : leaf_r[IW-1:0];
   end

   assign l_m1 = l_sel - IW'(1);
   assign r_m1 = r_sel - IW'(1);

   // in a replay the stored loser is side a and the challenger side b
   assign b_idx = (state_ff == ST_R_CMP) ? chal_ff : r_idx_ff;
   assign b_key = (state_ff == ST_R_CMP) ? chal_key_ff : pv_rd_b_ff;

   ltms_match #(
      .MAX_PLAYERS (MAX_PLAYERS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_match (
      .a_idx    (l_idx_ff),
      .a_key    (pv_rd_a_ff),
      .b_idx    (b_idx),
      .b_key    (b_key),
      .win_idx  (win_idx),
      .lose_idx (lose_idx),
      .win_key  (win_key)
   );

   // memory port control
   always_comb begin
      pv_we      = 1'b0;
      pv_waddr   = idx_m1[NW-1:0];
      pv_wdata   = val_key;
      pv_re      = (state_ff == ST_B_KEY) || (state_ff == ST_R_KEY);
      pv_raddr_a = l_m1[NW-1:0];
      pv_raddr_b = r_m1[NW-1:0];
      ws_re      = (state_ff == ST_B_WIN);
      ws_raddr_a = cl[NW-1:0];
      ws_raddr_b = cr[NW-1:0];
      ws_we      = (state_ff == ST_B_CMP);
      ln_we      = (state_ff == ST_B_CMP) || (state_ff == ST_R_CMP);
      ln_re      = (state_ff == ST_R_LOSE);
      if (item_go && (state_ff == ST_IDLE)) begin
         if ((req.func == FUNC_LOAD) && load_ok) begin
            pv_we = 1'b1;
         end
         if ((req.func == FUNC_REPLAY) && rep_ok) begin
            pv_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pv_we) begin
         pv_mem[pv_waddr] <= pv_wdata;
      end
      if (pv_re) begin
         pv_rd_a_ff <= pv_mem[pv_raddr_a];
         pv_rd_b_ff <= pv_mem[pv_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (ln_we) begin
         ln_mem[node_ff] <= lose_idx;
      end
      if (ln_re) begin
         ln_rd_ff <= ln_mem[node_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ws_we) begin
         ws_mem[node_ff] <= win_idx;
      end
      if (ws_re) begin
         ws_rd_a_ff <= ws_mem[ws_raddr_a];
         ws_rd_b_ff <= ws_mem[ws_raddr_b];
      end
   end

   assign last_node = (node_ff == NW'(1));

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      low_ext_in  = low_ext_ff;
      offset_in   = offset_ff;
      node_in     = node_ff;
      chal_in     = chal_ff;
      chal_key_in = chal_key_ff;
      l_idx_in    = l_idx_ff;
      r_idx_in    = r_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_go) begin
               if (req.func == FUNC_BUILD) begin
                  state_in = ST_SETUP;
               end else if ((req.func == FUNC_REPLAY) && rep_ok) begin
                  chal_in     = idx_iw;
                  chal_key_in = val_key;
                  node_in     = pos[PW-1:1];
                  state_in    = ST_R_LOSE;
               end
            end
         end
         ST_SETUP: begin
            count_in   = n_sat;
            low_ext_in = PW'(s_diff) << 1;
            offset_in  = (PW'(s_pow) << 1) - PW'(1);
            node_in    = nm1[NW-1:0];
            state_in   = ST_B_WIN;
         end
         ST_B_WIN: begin
            state_in = ST_B_KEY;
         end
         ST_B_KEY: begin
            l_idx_in = l_sel;
            r_idx_in = r_sel;
            state_in = ST_B_CMP;
         end
         ST_B_CMP: begin
            if (last_node) begin
               state_in = ST_IDLE;
            end else begin
               node_in  = node_ff - NW'(1);
               state_in = ST_B_WIN;
            end
         end
         ST_R_LOSE: begin
            state_in = ST_R_KEY;
         end
         ST_R_KEY: begin
            l_idx_in = l_sel;
            state_in = ST_R_CMP;
         end
         ST_R_CMP: begin
            chal_in     = win_idx;
            chal_key_in = win_key;
            if (last_node) begin
               state_in = ST_IDLE;
            end else begin
               node_in  = node_ff >> 1;
               state_in = ST_R_LOSE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= IW'(2);
         low_ext_ff <= PW'(2);
         offset_ff  <= PW'(1);
         chal_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         low_ext_ff <= low_ext_in;
         offset_ff  <= offset_in;
         chal_ff    <= chal_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      chal_key_ff <= chal_key_in;
      l_idx_ff    <= l_idx_in;
      r_idx_ff    <= r_idx_in;
   end

   assign win_idx_wide = {{IDX_W{1'b0}}, win_idx};
   assign win_key_wide = {{VAL_W{1'b0}}, win_key};

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.done = ((state_ff == ST_B_CMP) || (state_ff == ST_R_CMP)) && last_node;

   assign rsp_next.winner_index = win_idx_wide[IDX_W-1:0];
   assign rsp_next.winner_value = win_key_wide[VAL_W-1:0];

endmodule

// File: rtl/loser_tree_merge_selector.sv
// Loser tree k-way merge selector. An item is taken when start is high and busy is low.
// A load (func 0) or an ignored item frees the block at once and gives no result.
// A build (func 1) plays every internal node once through the single compare unit;
// each node passes a winner read, a key read (both registered) and a compare, and the
// result is strobed in the same cycle busy drops. A replay (func 2) plays each tree
// level on the player's path in turn: loser read, key read, compare; the result
// likewise comes in the cycle busy drops. Loads are free.
// The result is shown for exactly one cycle on rsp_strobe; the receiver
// cannot stall, so it must take every beat. No clearing pass after reset.
// Top level: depends on ltms_pkg and ltms_seq.
module loser_tree_merge_selector import ltms_pkg::*; #(
   parameter int MAX_PLAYERS = MAX_PLAYERS_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ltms_req_type       req_data,
   output logic               rsp_strobe,
   output ltms_rsp_type       rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   ltms_stat_type       stat;
   ltms_rsp_type        rsp_next;
   logic                item_go;
   logic [COUNT_W-1:0]  player_count_ff, player_count_in;
   logic                rsp_strobe_ff;
   ltms_rsp_type        rsp_data_ff;

   assign item_go   = start && !stat.busy;
   assign busy      = stat.busy;
   assign csr_ready = !stat.busy;

   assign player_count_in = (csr_valid && csr_ready) ? csr_data : player_count_ff;

   ltms_seq #(
      .MAX_PLAYERS (MAX_PLAYERS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .item_go      (item_go),
      .req          (req_data),
      .player_count (player_count_ff),
      .stat         (stat),
      .rsp_next     (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         player_count_ff <= COUNT_RESET;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         player_count_ff <= player_count_in;
         rsp_strobe_ff   <= stat.done;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // every result follows a stretch of work
   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without preceding work");

   // no two result beats back to back
   a_rsp_spaced : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beats in consecutive cycles");

   // a load never occupies the sequencer
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.func == FUNC_LOAD)) |=> !busy)
      else $error("load left the block busy");

endmodule

// File: dv/loser_tree_merge_selector_test.sv
// self-checking testbench for the loser tree merge selector: directed and random
// load, build and replay commands checked against an in-bench tournament predictor
// depends on ltms_pkg and the loser_tree_merge_selector rtl
`timescale 1ns / 100ps

module loser_tree_merge_selector_test;
   import ltms_pkg::*;

   localparam int MAX_P = MAX_PLAYERS_DEF;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int PHASES = 10;
   localparam int BEATS_PER_PHASE = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ltms_req_type req_data = '0;
   logic rsp_strobe;
   ltms_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_data = '0;

   loser_tree_merge_selector dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial forever #10 clock = ~clock;

   // pending commands and winners still owed by the block
   ltms_req_type cmd_q[$];
   ltms_rsp_type winner_q[$];

   int error_count = 0;
   int cmds_taken = 0;
   int winners_checked = 0;
   int builds_seen = 0;
   int replays_seen = 0;

   // predictor state
   logic [VAL_W-1:0]   player_key   [0:MAX_P];
   logic [IDX_W-1:0]   node_loser   [0:MAX_P];
   logic [IDX_W-1:0]   match_winner [0:MAX_P];
   logic [IDX_W-1:0]   carried = '0;
   logic [COUNT_W-1:0] cfg_player_count = COUNT_RESET;
   int built_n = 2;
   int low_ext = 2;
   int leaf_off = 1;

   // what the stimulus side knows is safe to read
   bit [MAX_P:0] plan_loaded = '0;
   bit plan_tree_ok = 1'b0;
   int plan_tree_n = 2;

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   function automatic void play_match(int p, int l, int r);
      // on equal keys the right player goes up
      if (player_key[l] >= player_key[r]) begin
         node_loser[p] = IDX_W'(l);
         match_winner[p] = IDX_W'(r);
      end else begin
         node_loser[p] = IDX_W'(r);
         match_winner[p] = IDX_W'(l);
      end
   endfunction

   function automatic void climb_matches(int p, int l, int r);
      play_match(p, l, r);
      while (p % 2 == 1 && p > 1) begin
         play_match(p / 2, match_winner[p - 1], match_winner[p]);
         p = p / 2;
      end
   endfunction

   function automatic void build_tree();
      int n;
      int s;
      int i;
      n = cfg_player_count;
      if (n < 2) n = 2;
      if (n > MAX_P) n = MAX_P;
      built_n = n;
      s = 1;
      while (2 * s <= n - 1) s = 2 * s;
      low_ext = 2 * (n - s);
      leaf_off = 2 * s - 1;
      for (i = 2; i <= low_ext; i += 2) climb_matches((leaf_off + i) / 2, i - 1, i);
      if (n % 2 == 1) begin
         climb_matches(n / 2, match_winner[n - 1], low_ext + 1);
         i = low_ext + 3;
      end else begin
         i = low_ext + 2;
      end
      while (i <= n) begin
         climb_matches((i - low_ext + n - 1) / 2, i - 1, i);
         i += 2;
      end
      node_loser[0] = match_winner[1];
   endfunction

   function automatic void replay_player(int who, logic [VAL_W-1:0] v);
      int node;
      logic [IDX_W-1:0] held;
      player_key[who] = v;
      carried = IDX_W'(who);
      if (who <= low_ext) node = (leaf_off + who) / 2;
      else node = (who - low_ext + built_n - 1) / 2;
      while (node >= 1) begin
         // strictly smaller loser takes over, equal keys leave it in place
         if (player_key[node_loser[node]] < player_key[carried]) begin
            held = node_loser[node];
            node_loser[node] = carried;
            carried = held;
         end
         if (node == 1) node_loser[0] = carried;
         node = node / 2;
      end
   endfunction

   function automatic void predict_winner(ltms_req_type r);
      ltms_rsp_type w;
      bit gives;
      gives = 1'b0;
      case (r.func)
         FUNC_LOAD: begin
            if (r.player_index >= 1 && r.player_index <= MAX_P)
               player_key[r.player_index] = r.value;
         end
         FUNC_BUILD: begin
            build_tree();
            builds_seen++;
            gives = 1'b1;
         end
         FUNC_REPLAY: begin
            if (r.player_index >= 1 && r.player_index <= built_n) begin
               replay_player(r.player_index, r.value);
               replays_seen++;
               gives = 1'b1;
            end
         end
         default: ;
      endcase
      if (gives) begin
         w.winner_index = node_loser[0];
         w.winner_value = player_key[node_loser[0]];
         winner_q.push_back(w);
      end
   endfunction

   function automatic void queue_cmd(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                     logic [VAL_W-1:0] v);
      ltms_req_type r;
      r.func = f;
      r.player_index = idx;
      r.value = v;
      cmd_q.push_back(r);
   endfunction

   // mix of tiny keys for ties, the two extremes, and full random
   function automatic logic [VAL_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return VAL_W'($urandom_range(0, 3));
         1: return $urandom_range(0, 1) ? {VAL_W{1'b1}} : {VAL_W{1'b0}};
         default: return $urandom;
      endcase
   endfunction

   function automatic int sat_count(int c);
      return (c < 2) ? 2 : (c > MAX_P) ? MAX_P : c;
   endfunction

   // load every slot the build will read, refresh a few, then build
   function automatic int queue_build(int eff);
      int queued;
      queued = 1;
      for (int i = 1; i <= eff; i++) begin
         if (!plan_loaded[i] || $urandom_range(0, 3) == 0) begin
            queue_cmd(FUNC_LOAD, IDX_W'(i), pick_key());
            plan_loaded[i] = 1'b1;
            queued++;
         end
      end
      queue_cmd(FUNC_BUILD, IDX_W'($urandom), $urandom);
      plan_tree_ok = 1'b1;
      plan_tree_n = eff;
      return queued;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_q.size() != 0 || start || busy || winner_q.size() != 0);
      // loads leave nothing to wait on, so give the block a few spare cycles
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] v);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      cfg_player_count = v;
      csr_valid <= 1'b0;
   endtask

   // driver: bursts of commands with random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : drive
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_winner(req_data);
            cmds_taken++;
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (cmd_q.size() != 0) begin
               req_data <= cmd_q.pop_front();
               start <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe is a beat that must match the oldest winner owed
   ltms_rsp_type want;

   always @(posedge clock) begin : watch
      if (!reset && rsp_strobe) begin
         winners_checked++;
         if (winner_q.size() == 0) begin
            flag_error($sformatf("unexpected winner: index %0d value %h",
                                 rsp_data.winner_index, rsp_data.winner_value));
         end else begin
            want = winner_q.pop_front();
            if (rsp_data.winner_index !== want.winner_index ||
                rsp_data.winner_value !== want.winner_value)
               flag_error($sformatf("winner mismatch: got index %0d value %h, want %0d %h",
                                    rsp_data.winner_index, rsp_data.winner_value,
                                    want.winner_index, want.winner_value));
         end
      end
   end

   initial begin : stimulus
      logic [COUNT_W-1:0] phase_count [PHASES];
      int eff;
      int useful;
      int roll;
      int idx;
      phase_count = '{7'd64, 7'd3, 7'd0, 7'd127, 7'd1, 7'd2, 7'd65, 7'd33, 7'd64, 7'd9};
      phase_count[8] = COUNT_W'($urandom_range(4, 63));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored codes and indexes, ties in build and replay, extremes
      queue_cmd(FUNC_UNUSED, 7'd127, {VAL_W{1'b1}});
      queue_cmd(FUNC_LOAD, 7'd0, $urandom);
      queue_cmd(FUNC_LOAD, 7'd65, $urandom);
      queue_cmd(FUNC_LOAD, 7'd127, $urandom);
      queue_cmd(FUNC_REPLAY, 7'd0, $urandom);
      queue_cmd(FUNC_REPLAY, 7'd3, $urandom);
      queue_cmd(FUNC_REPLAY, 7'd127, $urandom);
      queue_cmd(FUNC_LOAD, 7'd1, {VAL_W{1'b1}});
      queue_cmd(FUNC_LOAD, 7'd2, {VAL_W{1'b1}});
      queue_cmd(FUNC_BUILD, 7'd0, '0);
      queue_cmd(FUNC_REPLAY, 7'd2, {VAL_W{1'b1}});
      queue_cmd(FUNC_REPLAY, 7'd1, '0);
      queue_cmd(FUNC_REPLAY, 7'd2, '0);
      queue_cmd(FUNC_LOAD, 7'd64, '0);
      queue_cmd(FUNC_REPLAY, 7'd3, '0);
      queue_cmd(FUNC_LOAD, 7'd1, 32'h8000_0001);
      queue_cmd(FUNC_BUILD, 7'd127, {VAL_W{1'b1}});
      queue_cmd(FUNC_REPLAY, 7'd2, 32'h7fff_ffff);
      queue_cmd(FUNC_UNUSED, 7'd0, '0);
      plan_loaded[1] = 1'b1;
      plan_loaded[2] = 1'b1;
      plan_loaded[64] = 1'b1;
      plan_tree_ok = 1'b1;
      plan_tree_n = 2;

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         write_count(phase_count[ph]);
         eff = sat_count(phase_count[ph]);
         useful = queue_build(eff);
         while (useful < BEATS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               useful += queue_build(eff);
            end else if (roll < 70) begin
               queue_cmd(FUNC_REPLAY, IDX_W'($urandom_range(1, plan_tree_n)), pick_key());
               useful++;
            end else if (roll < 82) begin
               idx = $urandom_range(1, MAX_P);
               queue_cmd(FUNC_LOAD, IDX_W'(idx), pick_key());
               plan_loaded[idx] = 1'b1;
               useful++;
            end else begin
               case ($urandom_range(0, 3))
                  0: queue_cmd(FUNC_LOAD, $urandom_range(0, 1) ? 7'd0 :
                               IDX_W'($urandom_range(MAX_P + 1, 127)), $urandom);
                  1: queue_cmd(FUNC_REPLAY, 7'd0, $urandom);
                  2: queue_cmd(FUNC_REPLAY, IDX_W'($urandom_range(plan_tree_n + 1, 127)),
                               $urandom);
                  default: queue_cmd(FUNC_UNUSED, IDX_W'($urandom), $urandom);
               endcase
            end
         end
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (winner_q.size() != 0) begin
         error_count += winner_q.size() - 1;
         flag_error($sformatf("%0d winners never arrived", winner_q.size()));
      end
      $display("ran %0d commands over %0d tree size settings: %0d builds, %0d replays",
               cmds_taken, PHASES + 1, builds_seen, replays_seen);
      $display("checked %0d winner beats, %0d errors", winners_checked, error_count);
      if (error_count == 0) begin
         $display("[loser_tree_merge_selector] OK");
      end else begin
         $display("[loser_tree_merge_selector] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(50_000_000);
      $display("timeout with %0d commands and %0d winners pending", cmd_q.size(),
               winner_q.size());
      $display("[loser_tree_merge_selector] ERROR");
      $finish;
   end

endmodule
